[sv/bcsd_pkg.sv]
`default_nettype none

package bcsd_pkg;

	// default width of byte counts
	localparam int SIZE_BITS_DEF = 48;

	// block size register width
	localparam int BLK_W = 32;

	// reset values of the two registers
	localparam logic [BLK_W-1:0] RESET_BLOCK_BYTES = 32'd4096;
	localparam longint unsigned RESET_CHUNK_LIMIT = 64'd4096 * 64'd1024;

	// register select, taken from paddr bit 3
	localparam logic REG_BLOCK = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

endpackage

`default_nettype wire

[sv/best_chunk_size_divisor_core.sv]
`default_nettype none

// steps: when block_bytes is zero, an error result straight from idle; otherwise two divisions
// (DW = max(SIZE_BITS, 32)), then up to about sqrt(blocks) trial divisions, then a
// shift-add multiply; all share the registers of one radix-2 divider
// throughput: one item at a time, busy stays high until the done strobe cycle
// reset: registers return to 4096 and 4194304 bytes, no result pending
// the receiver cannot stall: each result is shown for exactly one cycle with done
module best_chunk_size_divisor_core
	import bcsd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// apb-style configuration port
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [63:0]          pwdata,
	output logic      [63:0]          prdata,
	output logic                      pready,
	// command side
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [SIZE_BITS-1:0] total_bytes,
	// result side
	output logic                      done,
	output logic      [SIZE_BITS-1:0] chunk_bytes,
	output logic      [SIZE_BITS-1:0] blocks_in_chunk,
	output logic                      status
);

	localparam int DW = (SIZE_BITS > BLK_W) ? SIZE_BITS : BLK_W;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_TOT,
		S_DIV_LIM,
		S_SEARCH,
		S_MUL
	} state_t;

	state_t                 state_q;
	logic [BLK_W-1:0]       blk_q;
	logic [SIZE_BITS-1:0]   lim_q;

	// shared divider / multiplier registers
	logic [DW-1:0]          rem_q;
	logic [DW-1:0]          quo_q;
	logic [DW-1:0]          dvs_q;
	logic [CW-1:0]          cnt_q;

	// search registers
	logic [SIZE_BITS-1:0]   blocks_q;
	logic [SIZE_BITS-1:0]   maxb_q;
	logic [SIZE_BITS-1:0]   best_q;
	logic [SIZE_BITS-1:0]   d_q;
	logic [SIZE_BITS-1:0]   chosen_q;

	logic                   done_q;
	logic [SIZE_BITS-1:0]   chunk_q;
	logic [SIZE_BITS-1:0]   blocks_out_q;
	logic                   status_q;

	// configuration port
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_LIMIT) ? 64'(lim_q) : 64'(blk_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q <= RESET_BLOCK_BYTES;
			lim_q <= SIZE_BITS'(RESET_CHUNK_LIMIT);
		end else if (cfg_wr) begin
			if (paddr[3] == REG_BLOCK) begin
				blk_q <= pwdata[BLK_W-1:0];
			end else begin
				lim_q <= pwdata[SIZE_BITS-1:0];
			end
		end
	end

	// one restoring divide step
	logic [DW:0]   div_shift;
	logic          div_ge;
	logic [DW:0]   div_diff;
	logic [DW-1:0] div_rem_nx;
	logic [DW-1:0] div_quo_nx;

	assign div_shift  = {rem_q, quo_q[DW-1]};
	assign div_ge     = div_shift >= {1'b0, dvs_q};
	assign div_diff   = div_shift - {1'b0, dvs_q};
	assign div_rem_nx = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
	assign div_quo_nx = {quo_q[DW-2:0], div_ge};

	// one shift-add multiply step, multiplier bits taken msb first
	logic [DW-1:0] mul_acc_nx;
	assign mul_acc_nx = {rem_q[DW-2:0], 1'b0} +
		(quo_q[BLK_W-1] ? DW'(chosen_q) : '0);

	// finished division, narrowed to byte-count width
	logic [SIZE_BITS-1:0] quo_w;
	logic                 rem_zero;
	logic [SIZE_BITS-1:0] d_next;
	assign quo_w    = quo_q[SIZE_BITS-1:0];
	assign rem_zero = (rem_q == '0);
	assign d_next   = d_q + SIZE_BITS'(1);

	// sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rem_q        <= '0;
			quo_q        <= '0;
			dvs_q        <= '0;
			cnt_q        <= '0;
			blocks_q     <= '0;
			maxb_q       <= '0;
			best_q       <= '0;
			d_q          <= '0;
			chosen_q     <= '0;
			done_q       <= 1'b0;
			chunk_q      <= '0;
			blocks_out_q <= '0;
			status_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (blk_q == '0) begin
							done_q       <= 1'b1;
							chunk_q      <= '0;
							blocks_out_q <= '0;
							status_q     <= 1'b1;
						end else begin
							rem_q   <= '0;
							quo_q   <= DW'(total_bytes);
							dvs_q   <= DW'(blk_q);
							cnt_q   <= CW'(DW);
							state_q <= S_DIV_TOT;
						end
					end
				end
				S_DIV_TOT, S_DIV_LIM, S_SEARCH: begin
					if (cnt_q != '0) begin
						rem_q <= div_rem_nx;
						quo_q <= div_quo_nx;
						cnt_q <= cnt_q - CW'(1);
					end else begin
						priority if ((state_q != S_SEARCH) && (quo_w == '0 || !rem_zero)) begin
							// too small or not a block multiple
							done_q       <= 1'b1;
							chunk_q      <= '0;
							blocks_out_q <= '0;
							status_q     <= 1'b1;
							state_q      <= S_IDLE;
						end else if (state_q == S_DIV_TOT) begin
							blocks_q <= quo_w;
							rem_q    <= '0;
							quo_q    <= DW'(lim_q);
							cnt_q    <= CW'(DW);
							state_q  <= S_DIV_LIM;
						end else if (state_q == S_DIV_LIM) begin
							maxb_q <= quo_w;
							if (blocks_q <= quo_w) begin
								// whole file fits in one chunk
								chosen_q <= blocks_q;
								rem_q    <= '0;
								quo_q    <= DW'(blk_q);
								cnt_q    <= CW'(BLK_W);
								state_q  <= S_MUL;
							end else begin
								best_q  <= SIZE_BITS'(1);
								d_q     <= SIZE_BITS'(1);
								rem_q   <= '0;
								quo_q   <= DW'(blocks_q);
								dvs_q   <= DW'(SIZE_BITS'(1));
								cnt_q   <= CW'(DW);
								state_q <= S_SEARCH;
							end
						end else if (quo_w < d_q) begin
							// passed the square root, keep best small divisor
							chosen_q <= best_q;
							rem_q    <= '0;
							quo_q    <= DW'(blk_q);
							cnt_q    <= CW'(BLK_W);
							state_q  <= S_MUL;
						end else if (rem_zero && quo_w <= maxb_q) begin
							// largest paired divisor that fits
							chosen_q <= (quo_w > best_q) ? quo_w : best_q;
							rem_q    <= '0;
							quo_q    <= DW'(blk_q);
							cnt_q    <= CW'(BLK_W);
							state_q  <= S_MUL;
						end else begin
							if (rem_zero && d_q <= maxb_q && d_q > best_q) begin
								best_q <= d_q;
							end
							d_q   <= d_next;
							rem_q <= '0;
							quo_q <= DW'(blocks_q);
							dvs_q <= DW'(d_next);
							cnt_q <= CW'(DW);
						end
					end
				end
				S_MUL: begin
					if (cnt_q != '0) begin
						rem_q <= mul_acc_nx;
						quo_q <= {quo_q[DW-2:0], 1'b0};
						cnt_q <= cnt_q - CW'(1);
					end else begin
						done_q       <= 1'b1;
						chunk_q      <= rem_q[SIZE_BITS-1:0];
						blocks_out_q <= chosen_q;
						status_q     <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign chunk_bytes     = chunk_q;
	assign blocks_in_chunk = blocks_out_q;
	assign status          = status_q;

	// a result beat only appears once the sequencer is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// error beats carry zero sizes
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (chunk_bytes == '0 && blocks_in_chunk == '0))
		else $error("error beat with nonzero sizes");

	// a good beat has at least one block per chunk
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !status) |-> (blocks_in_chunk != '0))
		else $error("good beat with zero blocks");

	// an accepted item with a valid block size keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && blk_q != '0) |=> busy)
		else $error("accepted item did not start the sequencer");

	// the running best divisor never exceeds the block limit
	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (best_q <= maxb_q))
		else $error("best divisor above limit");

endmodule

`default_nettype wire
